FILE: src/mep_pkg.sv
`timescale 1ns / 1ps

package mep_pkg;

  localparam int unsigned COORD_BITS = 32;
  localparam int unsigned FRAC_BITS  = 28;
  localparam int unsigned MAX_ITER   = 127;
  localparam int unsigned ITER_BITS  = $clog2(MAX_ITER + 1);
  localparam int unsigned CFG_BITS   = 32;
  localparam int unsigned DIM_BITS   = 13;
  localparam int unsigned IDX_BITS   = 12;
  localparam int unsigned COLOR_BITS = 24;
  localparam int unsigned ADDR_BITS  = 3;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [ITER_BITS-1:0]         iter_t;
  typedef logic [IDX_BITS-1:0]          idx_t;
  typedef logic [COLOR_BITS-1:0]        color_t;

  // Register indexes on the configuration port
  typedef enum logic [ADDR_BITS-1:0] {
    REG_REAL_ORIGIN = 3'd0,
    REG_IMAG_ORIGIN = 3'd1,
    REG_REAL_INC    = 3'd2,
    REG_IMAG_INC    = 3'd3,
    REG_COLUMNS     = 3'd4,
    REG_ROWS        = 3'd5
  } reg_addr_e;

  // Status of the escape-time unit seen by the top level
  typedef struct packed {
    logic  idle;
    logic  done;
    iter_t count;
  } core_stat_t;

  function automatic color_t palette(input logic [3:0] sel);
    color_t c;
    case (sel)
      4'd0:    c = 24'hff0000;
      4'd1:    c = 24'hee3300;
      4'd2:    c = 24'hcc5500;
      4'd3:    c = 24'haa5500;
      4'd4:    c = 24'haa3300;
      4'd5:    c = 24'h666600;
      4'd6:    c = 24'h999900;
      4'd7:    c = 24'h669900;
      4'd8:    c = 24'h339900;
      4'd9:    c = 24'h0099aa;
      4'd10:   c = 24'h0066aa;
      4'd11:   c = 24'h0033aa;
      4'd12:   c = 24'h0000aa;
      4'd13:   c = 24'h000099;
      4'd14:   c = 24'h000066;
      default: c = 24'h000000;
    endcase
    return c;
  endfunction

  // Last index of a dimension: zero acts as one, above 4096 acts as 4096
  function automatic idx_t last_index(input logic [DIM_BITS-1:0] dim);
    idx_t r;
    if (dim == '0) begin
      r = '0;
    end else if (dim > DIM_BITS'(1 << IDX_BITS)) begin
      r = '1;
    end else begin
      r = IDX_BITS'(dim - DIM_BITS'(1));
    end
    return r;
  endfunction

endpackage

FILE: src/mandelbrot_escape_time_pixel.sv
`timescale 1ns / 1ps
// One pixel at a time, set by the single shared 32x32 multiplier; the next request is
// taken the cycle after the escape unit hands its result to the output register. Reset
// (rst_ni low, asynchronous): walk at top-left, coordinates and registers zero, 1024
// columns by 768 rows, no result pending.
module mandelbrot_escape_time_pixel (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Pixel requests
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] restart, [7:1] zero
  // Pixel results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [23:0] color, [30:24] iterations, [31] zero
  output logic        m_axis_tuser,   // [0] row_done
  output logic        m_axis_tlast,   // frame_done
  // Register writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_addr_i,
  input  logic [31:0] cfg_data_i
);
  import mep_pkg::*;

  // Configuration registers
  coord_t                real_origin_q, imag_origin_q, real_inc_q, imag_inc_q;
  logic [DIM_BITS-1:0]   columns_q, rows_q;

  // Raster walk state
  coord_t cur_real_q, cur_imag_q;
  idx_t   col_q, row_q;

  // Pixel marks held while the escape unit runs
  logic   row_end_q, frame_end_q;

  // Output register
  logic   out_valid_q;
  color_t color_q;
  iter_t  iter_q;
  logic   row_done_q, frame_done_q;

  core_stat_t stat;
  logic       accept, restart, hand_over;
  coord_t     cr_use, ci_use;
  idx_t       col_use, row_use, last_col, last_row;
  logic       row_end, frame_end;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      real_origin_q <= '0;
      imag_origin_q <= '0;
      real_inc_q    <= '0;
      imag_inc_q    <= '0;
      columns_q     <= DIM_BITS'(1024);
      rows_q        <= DIM_BITS'(768);
    end else if (cfg_valid_i) begin
      // Drop writes to indexes beyond the register list
      case (cfg_addr_i)
        REG_REAL_ORIGIN: real_origin_q <= coord_t'(signed'(cfg_data_i));
        REG_IMAG_ORIGIN: imag_origin_q <= coord_t'(signed'(cfg_data_i));
        REG_REAL_INC:    real_inc_q    <= coord_t'(signed'(cfg_data_i));
        REG_IMAG_INC:    imag_inc_q    <= coord_t'(signed'(cfg_data_i));
        REG_COLUMNS:     columns_q     <= cfg_data_i[DIM_BITS-1:0];
        REG_ROWS:        rows_q        <= cfg_data_i[DIM_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Take a request only while the escape unit is free
  assign s_axis_tready = stat.idle;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign restart       = s_axis_tdata[0];

  // A restart jumps to the top-left pixel before this request is worked
  assign cr_use  = restart ? real_origin_q : cur_real_q;
  assign ci_use  = restart ? imag_origin_q : cur_imag_q;
  assign col_use = restart ? '0 : col_q;
  assign row_use = restart ? '0 : row_q;

  // An index at or past the last position (geometry shrunk mid-frame) counts as last
  assign last_col  = last_index(columns_q);
  assign last_row  = last_index(rows_q);
  assign row_end   = col_use >= last_col;
  assign frame_end = row_end && (row_use >= last_row);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_real_q  <= '0;
      cur_imag_q  <= '0;
      col_q       <= '0;
      row_q       <= '0;
      row_end_q   <= 1'b0;
      frame_end_q <= 1'b0;
    end else if (accept) begin
      row_end_q   <= row_end;
      frame_end_q <= frame_end;
      if (row_end) begin
        // Wrap to the start of the next row, or of the next frame
        col_q      <= '0;
        cur_real_q <= real_origin_q;
        if (frame_end) begin
          row_q      <= '0;
          cur_imag_q <= imag_origin_q;
        end else begin
          row_q      <= row_use + idx_t'(1);
          cur_imag_q <= ci_use + imag_inc_q;
        end
      end else begin
        // Advance one column along the row
        col_q      <= col_use + idx_t'(1);
        row_q      <= row_use;
        cur_imag_q <= ci_use;
        cur_real_q <= cr_use + real_inc_q;
      end
    end
  end

  mep_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .cr_i    (cr_use),
    .ci_i    (ci_use),
    .ack_i   (hand_over),
    .stat_o  (stat)
  );

  // Move a finished pixel into the output register when it is empty or being drained
  assign hand_over = stat.done && (!out_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (hand_over) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Payload of the output register, no reset needed
  always_ff @(posedge clk_i) begin
    if (hand_over) begin
      iter_q       <= stat.count;
      color_q      <= palette(4'(stat.count >> 3));
      row_done_q   <= row_end_q;
      frame_done_q <= frame_end_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, iter_q, color_q};
  assign m_axis_tuser  = row_done_q;
  assign m_axis_tlast  = frame_done_q;

endmodule

FILE: src/mep_core.sv
`timescale 1ns / 1ps

module mep_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  mep_pkg::coord_t cr_i,
  input  mep_pkg::coord_t ci_i,
  input  logic            ack_i,
  output mep_pkg::core_stat_t stat_o
);
  import mep_pkg::*;

  localparam coord_t TWO     = coord_t'(COORD_BITS'(1) << (FRAC_BITS + 1));
  localparam coord_t NEG_TWO = -TWO;
  localparam coord_t FOUR    = coord_t'(COORD_BITS'(1) << (FRAC_BITS + 2));

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_T,
    ST_UPD,
    ST_SQR,
    ST_SQI,
    ST_CHK,
    ST_DONE
  } state_e;

  state_e state_q;
  coord_t zr_q, zi_q, sr_q, si_q, cr_q, ci_q, prod_q;
  iter_t  n_q, count_q;

  coord_t op_a, op_b, prod_d, zr_n, zi_n, mag;
  logic signed [2*COORD_BITS-1:0] full;
  logic   bound_hit;

  // Shared multiplier: doubled real times imaginary, or a square
  always_comb begin
    case (state_q)
      ST_SQR: begin
        op_a = zr_q;
        op_b = zr_q;
      end
      ST_SQI: begin
        op_a = zi_q;
        op_b = zi_q;
      end
      default: begin
        op_a = zr_q <<< 1;
        op_b = zi_q;
      end
    endcase
    full   = (2*COORD_BITS)'(op_a) * (2*COORD_BITS)'(op_b);
    prod_d = full[FRAC_BITS +: COORD_BITS];
  end

  assign zr_n      = sr_q - si_q + cr_q;
  assign zi_n      = prod_q + ci_q;
  assign bound_hit = (zr_n >= TWO) || (zr_n <= NEG_TWO) ||
                     (zi_n >= TWO) || (zi_n <= NEG_TWO);
  assign mag       = sr_q + prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      zr_q    <= '0;
      zi_q    <= '0;
      sr_q    <= '0;
      si_q    <= '0;
      cr_q    <= '0;
      ci_q    <= '0;
      prod_q  <= '0;
      n_q     <= '0;
      count_q <= '0;
    end else begin
      prod_q <= prod_d;
      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            zr_q    <= '0;
            zi_q    <= '0;
            sr_q    <= '0;
            si_q    <= '0;
            cr_q    <= cr_i;
            ci_q    <= ci_i;
            n_q     <= '0;
            state_q <= ST_MUL_T;
          end
        end
        ST_MUL_T: state_q <= ST_UPD;
        ST_UPD: begin
          zr_q <= zr_n;
          zi_q <= zi_n;
          if (bound_hit) begin
            count_q <= n_q;
            state_q <= ST_DONE;
          end else begin
            state_q <= ST_SQR;
          end
        end
        ST_SQR: state_q <= ST_SQI;
        ST_SQI: begin
          sr_q    <= prod_q;
          state_q <= ST_CHK;
        end
        ST_CHK: begin
          // The squares kept here feed the next update
          si_q <= prod_q;
          if (mag >= FOUR) begin
            count_q <= n_q;
            state_q <= ST_DONE;
          end else if (n_q == iter_t'(MAX_ITER - 1)) begin
            count_q <= iter_t'(MAX_ITER);
            state_q <= ST_DONE;
          end else begin
            n_q     <= n_q + iter_t'(1);
            state_q <= ST_UPD;
          end
        end
        ST_DONE: begin
          if (ack_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign stat_o.idle  = (state_q == ST_IDLE);
  assign stat_o.done  = (state_q == ST_DONE);
  assign stat_o.count = count_q;

endmodule
